### rtl/mpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_pkg: shared types and constants
// Payload structs, operation codes, datapath command and status types.
// ----------------------------------------------------------------------------
package mpp_pkg;

  typedef enum logic [1:0] {
    OP_STRAIGHT = 2'd0,
    OP_TURN     = 2'd1,
    OP_BRAKE    = 2'd2,
    OP_MEASURE  = 2'd3
  } op_t;

  localparam logic [2:0] REG_DIA   = 3'd0;
  localparam logic [2:0] REG_BASE  = 3'd1;
  localparam logic [2:0] REG_DECEL = 3'd2;
  localparam logic [2:0] REG_GEAR  = 3'd3;
  localparam logic [2:0] REG_PPR   = 3'd4;

  // sequencer step codes shared by controller and datapath
  localparam logic [4:0] ST_LOAD  = 5'd0;
  localparam logic [4:0] ST_DECEL = 5'd1;
  localparam logic [4:0] ST_TOT   = 5'd2;
  localparam logic [4:0] ST_SPD   = 5'd3;
  localparam logic [4:0] ST_BRK   = 5'd4;
  localparam logic [4:0] ST_SQ    = 5'd5;
  localparam logic [4:0] ST_ROOT  = 5'd6;
  localparam logic [4:0] ST_FIN   = 5'd7;
  localparam logic [4:0] ST_E0    = 5'd8;
  localparam logic [4:0] ST_E1    = 5'd9;
  localparam logic [4:0] ST_EFIN  = 5'd10;

  localparam logic [35:0] PI_Q32 = 36'h3243F6A88;
  localparam logic [63:0] SAT31  = 64'h7FFFFFFF;
  localparam logic [63:0] LIM62  = 64'h3FFFFFFFFFFFFFFF;
  localparam logic [63:0] LIM40  = 64'h10000000000;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] distance_mm;
    logic signed [15:0] speed_mm_s;
    logic signed [15:0] turn_degrees;
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
  } in_item_t;

  typedef struct packed {
    logic [30:0]        total_distance;
    logic [30:0]        brake_distance;
    logic signed [31:0] cruise_distance;
    logic [30:0]        final_speed;
    logic               speed_capped;
    logic               right_forward;
    logic               left_forward;
    logic [15:0]        stop_adjust;
    logic signed [31:0] err_right;
    logic signed [31:0] err_left;
    logic signed [31:0] err_right_total;
    logic signed [31:0] err_left_total;
  } out_item_t;

  // muldiv request: floor(a*b/d) saturated at lim
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
    logic [63:0] lim;
  } md_cmd_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } md_sts_t;

  typedef struct packed {
    logic        start;
    logic [63:0] v;
  } sq_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] r;
  } sq_sts_t;

endpackage

### rtl/mpp_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_muldiv: sequential multiply then divide
// 64x64 product over four 32x32 partial products, then restoring division
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpp_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  mpp_pkg::md_cmd_t cmd,
  output mpp_pkg::md_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_CHK, S_DIV, S_DONE} st_t;

  st_t         state;
  logic [1:0]  pp_idx;
  logic [6:0]  bit_idx;
  logic [63:0] a, b, d, lim;
  logic [127:0] prod;
  logic [63:0] r, q;
  logic [63:0] pp;
  logic [31:0] pa, pb;
  logic [64:0] r_sh;
  logic        top;

  always_comb begin
    pa = pp_idx[0] ? a[63:32] : a[31:0];
    pb = pp_idx[1] ? b[63:32] : b[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    top  = r[63];
    r_sh = {r, prod[bit_idx[5:0]]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd.start) begin
          a <= cmd.a; b <= cmd.b; d <= cmd.d; lim <= cmd.lim;
          prod <= '0; pp_idx <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= prod + ({64'd0, pp} << {pp_idx[1] ^ pp_idx[0] ? 7'd32 :
                                          (pp_idx[1] ? 7'd64 : 7'd0)});
          pp_idx <= pp_idx + 2'd1;
          if (pp_idx == 2'd3) state <= S_CHK;
        end
        S_CHK: begin
          if (d == 64'd0 || prod[127:64] >= d) begin
            sts.q <= lim; sts.done <= 1'b1; state <= S_IDLE;
          end else begin
            r <= prod[127:64]; q <= '0; bit_idx <= 7'd63;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (top || r_sh[63:0] >= d) begin
            r <= r_sh[63:0] - d;
            q[bit_idx[5:0]] <= 1'b1;
          end else begin
            r <= r_sh[63:0];
          end
          if (bit_idx == 7'd0) state <= S_DONE;
          else bit_idx <= bit_idx - 7'd1;
        end
        S_DONE: begin
          sts.q <= (q > lim) ? lim : q;
          sts.done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/mpp_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_isqrt: sequential integer square root
// Digit-by-digit root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module mpp_isqrt (
  input  logic             clk,
  input  logic             rst,
  input  mpp_pkg::sq_cmd_t cmd,
  output mpp_pkg::sq_sts_t sts
);

  logic        busy;
  logic [63:0] v, res, bitv;
  logic [63:0] trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (!busy) begin
        if (cmd.start) begin
          v <= cmd.v; res <= '0; bitv <= 64'd1 << 62; busy <= 1'b1;
        end
      end else if (bitv == 64'd0) begin
        sts.r <= res[31:0]; sts.done <= 1'b1; busy <= 1'b0;
      end else begin
        if (v >= trial) begin
          v <= v - trial; res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
    end
  end

endmodule

### rtl/mpp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_datapath: plan registers and arithmetic units
// Holds config and plan state; executes one step per controller command.
// ----------------------------------------------------------------------------
module mpp_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_data,
  input  logic [4:0]         step,
  input  logic               step_go,
  input  mpp_pkg::in_item_t  item,
  output logic               unit_done,
  output mpp_pkg::out_item_t result
);

  localparam int SH = 32 - FRAC_BITS;

  logic [15:0] wheel_diameter, wheel_base, decel_rpm_per_s, gear_ratio, pulses_per_rev;
  logic [31:0] plan_total, plan_brake, plan_speed;
  logic signed [31:0] plan_cruise;
  logic plan_capped, dir_right, dir_left;
  logic [15:0] adjust_reg;
  logic signed [31:0] wheel_errors [4];

  logic [63:0] tot, spd, acc, brk, ang_r, sqv, root_v;
  mpp_pkg::in_item_t it;
  mpp_pkg::md_cmd_t md_cmd;
  mpp_pkg::md_sts_t md_sts;
  mpp_pkg::sq_cmd_t sq_cmd;
  mpp_pkg::sq_sts_t sq_sts;

  logic [63:0] dia, base, dec, gear, ppr;
  logic [15:0] dmag, smag, deg;
  logic [15:0] dcm, scm;
  logic [31:0] rmag, lmag;
  logic [63:0] spd_sq;
  logic [2:0]  band;
  logic [15:0] adj;
  logic signed [31:0] e100, e10;

  function automatic logic [15:0] mag16(input logic [15:0] x);
    mag16 = x[15] ? 16'(17'h10000 - {1'b0, x}) : x;
  endfunction
  function automatic logic [31:0] mag32(input logic [31:0] x);
    mag32 = x[31] ? 32'(33'h100000000 - {1'b0, x}) : x;
  endfunction
  function automatic logic signed [31:0] werr(input logic signed [63:0] ref_v,
                                              input logic neg, input logic [63:0] ang);
    logic signed [63:0] e;
    e = neg ? ref_v + $signed(ang) : ref_v - $signed(ang);
    if (e > 64'sd2147483647) werr = 32'sh7FFFFFFF;
    else if (e < -64'sd2147483648) werr = 32'sh80000000;
    else werr = e[31:0];
  endfunction

  always_comb begin
    dia  = (wheel_diameter == 0) ? 64'd1 : {48'd0, wheel_diameter};
    base = (wheel_base == 0) ? 64'd1 : {48'd0, wheel_base};
    dec  = (decel_rpm_per_s == 0) ? 64'd1 : {48'd0, decel_rpm_per_s};
    gear = (gear_ratio == 0) ? 64'd1 : {48'd0, gear_ratio};
    ppr  = (pulses_per_rev == 0) ? 64'd1 : {48'd0, pulses_per_rev};
    dmag = mag16(it.distance_mm);
    smag = mag16(it.speed_mm_s);
    deg  = mag16(it.turn_degrees);
    // mm to cm: reciprocal of ten, exact over the 16-bit magnitude range
    dcm  = 16'((32'(dmag) * 32'd52429) >> 19);
    scm  = 16'((32'(smag) * 32'd52429) >> 19);
    rmag = mag32(it.right_count);
    lmag = mag32(it.left_count);
    spd_sq = spd[31:0] * spd[31:0];
    band = 3'(deg > 16'd15) + 3'(deg > 16'd30) + 3'(deg > 16'd60) +
           3'(deg > 16'd90) + 3'(deg > 16'd120) + 3'(deg > 16'd150);
    unique case (band)
      3'd0: adj = 16'd328;
      3'd1: adj = 16'd655;
      3'd2: adj = 16'd983;
      3'd3: adj = 16'd5243;
      3'd4: adj = 16'd6554;
      3'd5: adj = 16'd9830;
      default: adj = 16'd16384;
    endcase
    e100 = 32'(64'd100 << FRAC_BITS);
    e10  = 32'(64'd10 << FRAC_BITS);
  end

  // unit commands, issued on step_go
  always_comb begin
    md_cmd = '0;
    sq_cmd = '0;
    md_cmd.lim = mpp_pkg::SAT31;
    unique case (step)
      mpp_pkg::ST_DECEL: begin
        md_cmd.a = dec * 64'd256; md_cmd.b = {28'd0, mpp_pkg::PI_Q32};
        md_cmd.d = 64'd30 * gear; md_cmd.lim = mpp_pkg::LIM62;
      end
      mpp_pkg::ST_TOT: begin
        if (it.operation == mpp_pkg::OP_TURN) begin
          md_cmd.a = {48'd0, deg} * base * 64'd2; md_cmd.b = {28'd0, mpp_pkg::PI_Q32};
          md_cmd.d = (64'd360 * dia) << SH;
        end else begin
          md_cmd.a = {48'd0, dcm} * 64'd512; md_cmd.b = 64'd1 << FRAC_BITS;
          md_cmd.d = dia;
        end
      end
      mpp_pkg::ST_SPD: begin
        md_cmd.a = {48'd0, scm} * 64'd512; md_cmd.b = 64'd1 << FRAC_BITS;
        md_cmd.d = dia;
      end
      mpp_pkg::ST_BRK: begin
        md_cmd.a = spd_sq; md_cmd.b = 64'd1 << SH; md_cmd.d = acc << 1;
      end
      mpp_pkg::ST_SQ: begin
        md_cmd.a = acc << 1; md_cmd.b = tot >> 1; md_cmd.d = 64'd1 << SH;
        md_cmd.lim = mpp_pkg::LIM62;
      end
      mpp_pkg::ST_ROOT: sq_cmd.v = sqv;
      mpp_pkg::ST_E0, mpp_pkg::ST_E1: begin
        md_cmd.a = {32'd0, (step == mpp_pkg::ST_E0) ? rmag : lmag} * 64'd512;
        md_cmd.b = {28'd0, mpp_pkg::PI_Q32};
        md_cmd.d = (ppr * gear) << SH; md_cmd.lim = mpp_pkg::LIM40;
      end
      default: ;
    endcase
    md_cmd.start = step_go && step != mpp_pkg::ST_ROOT && step != mpp_pkg::ST_LOAD &&
                   step != mpp_pkg::ST_FIN && step != mpp_pkg::ST_EFIN;
    sq_cmd.start = step_go && step == mpp_pkg::ST_ROOT;
  end

  assign unit_done = md_sts.done | sq_sts.done;

  mpp_muldiv u_md (.clk(clk), .rst(rst), .cmd(md_cmd), .sts(md_sts));
  mpp_isqrt  u_sq (.clk(clk), .rst(rst), .cmd(sq_cmd), .sts(sq_sts));

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_diameter <= 16'd1536; wheel_base <= 16'd7680; decel_rpm_per_s <= 16'd100;
      gear_ratio <= 16'd7680; pulses_per_rev <= 16'd48;
      plan_total <= '0; plan_brake <= '0; plan_cruise <= '0; plan_speed <= '0;
      plan_capped <= 1'b0; dir_right <= 1'b1; dir_left <= 1'b1; adjust_reg <= '0;
      for (int k = 0; k < 4; k++) wheel_errors[k] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          mpp_pkg::REG_DIA:   wheel_diameter  <= cfg_data;
          mpp_pkg::REG_BASE:  wheel_base      <= cfg_data;
          mpp_pkg::REG_DECEL: decel_rpm_per_s <= cfg_data;
          mpp_pkg::REG_GEAR:  gear_ratio      <= cfg_data;
          mpp_pkg::REG_PPR:   pulses_per_rev  <= cfg_data;
          default: ;
        endcase
      end
      if (step == mpp_pkg::ST_LOAD && step_go) it <= item;
      if (md_sts.done) begin
        unique case (step)
          mpp_pkg::ST_DECEL: begin
            acc <= md_sts.q;
            // brake starts from the planned speed, a turn from 2.5 rad/s
            if (it.operation == mpp_pkg::OP_BRAKE) spd <= {32'd0, plan_speed};
            else if (it.operation == mpp_pkg::OP_TURN) spd <= 64'd5 << (FRAC_BITS - 1);
          end
          mpp_pkg::ST_TOT:   tot <= md_sts.q;
          mpp_pkg::ST_SPD:   spd <= md_sts.q;
          mpp_pkg::ST_BRK:   brk <= md_sts.q;
          mpp_pkg::ST_SQ:    sqv <= md_sts.q;
          mpp_pkg::ST_E0:    ang_r <= md_sts.q;
          mpp_pkg::ST_E1:    brk <= md_sts.q;
          default:  ;
        endcase
      end
      if (sq_sts.done) root_v <= {32'd0, sq_sts.r} > mpp_pkg::SAT31 ? mpp_pkg::SAT31
                                                                    : {32'd0, sq_sts.r};
      // commit plan: brk/spd/root_v hold final values here
      if (step_go && step == mpp_pkg::ST_FIN) begin
        if (it.operation == mpp_pkg::OP_BRAKE) begin
          plan_brake <= brk[31:0]; plan_total <= brk[31:0]; plan_speed <= '0;
          wheel_errors[2] <= e100; wheel_errors[3] <= e100;
        end else begin
          plan_total <= tot[31:0];
          if ((brk << 1) > tot) begin
            plan_brake <= 32'(tot >> 1); plan_cruise <= 32'(tot >> 1);
            plan_speed <= root_v[31:0]; plan_capped <= 1'b1;
          end else begin
            plan_brake <= brk[31:0]; plan_cruise <= 32'(tot - brk);
            plan_speed <= spd[31:0]; plan_capped <= 1'b0;
          end
          wheel_errors[0] <= e100; wheel_errors[1] <= e100;
          if (it.operation == mpp_pkg::OP_TURN) begin
            dir_right <= !(!it.turn_degrees[15] && it.turn_degrees != 0);
            dir_left  <= !it.turn_degrees[15] && it.turn_degrees != 0;
            wheel_errors[2] <= e10; wheel_errors[3] <= e10;
            adjust_reg <= adj;
          end else begin
            dir_right <= !it.distance_mm[15] && it.distance_mm != 0;
            dir_left  <= !it.distance_mm[15] && it.distance_mm != 0;
            wheel_errors[2] <= e100; wheel_errors[3] <= e100;
            adjust_reg <= 16'd66;
          end
        end
      end
      if (step_go && step == mpp_pkg::ST_EFIN) begin
        wheel_errors[0] <= werr(64'(plan_cruise), it.right_count[31], ang_r);
        wheel_errors[1] <= werr(64'(plan_cruise), it.left_count[31], brk);
        wheel_errors[2] <= werr({32'd0, plan_total}, it.right_count[31], ang_r);
        wheel_errors[3] <= werr({32'd0, plan_total}, it.left_count[31], brk);
      end
    end
  end

  always_comb begin
    result.total_distance  = plan_total[30:0];
    result.brake_distance  = plan_brake[30:0];
    result.cruise_distance = plan_cruise;
    result.final_speed     = plan_speed[30:0];
    result.speed_capped    = plan_capped;
    result.right_forward   = dir_right;
    result.left_forward    = dir_left;
    result.stop_adjust     = adjust_reg;
    result.err_right       = wheel_errors[0];
    result.err_left        = wheel_errors[1];
    result.err_right_total = wheel_errors[2];
    result.err_left_total  = wheel_errors[3];
  end

endmodule

### rtl/mpp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_ctrl: step sequencer
// Walks the datapath through the steps of one operation and runs the
// channel handshakes.
// ----------------------------------------------------------------------------
module mpp_ctrl (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  logic       unit_done,
  output logic [4:0] step,
  output logic       step_go
);

  typedef enum logic [1:0] {C_IDLE, C_ISSUE, C_WAIT, C_OUT} cst_t;

  cst_t       state;
  logic [1:0] op;
  logic [4:0] nxt;

  // a straight or turn move needs the root only when capped; datapath tells
  // by value, so sequence always runs it (result is unused when not capped)
  always_comb begin
    unique case (step)
      mpp_pkg::ST_DECEL: nxt = (op == mpp_pkg::OP_BRAKE) ? mpp_pkg::ST_BRK : mpp_pkg::ST_TOT;
      mpp_pkg::ST_TOT:   nxt = (op == mpp_pkg::OP_STRAIGHT) ? mpp_pkg::ST_SPD
                                                            : mpp_pkg::ST_BRK;
      mpp_pkg::ST_SPD:   nxt = mpp_pkg::ST_BRK;
      mpp_pkg::ST_BRK:   nxt = (op == mpp_pkg::OP_BRAKE) ? mpp_pkg::ST_FIN : mpp_pkg::ST_SQ;
      mpp_pkg::ST_SQ:    nxt = mpp_pkg::ST_ROOT;
      mpp_pkg::ST_ROOT:  nxt = mpp_pkg::ST_FIN;
      mpp_pkg::ST_E0:    nxt = mpp_pkg::ST_E1;
      mpp_pkg::ST_E1:    nxt = mpp_pkg::ST_EFIN;
      default:           nxt = mpp_pkg::ST_FIN;
    endcase
  end

  assign in_ready = (state == C_IDLE) || (state == C_OUT && out_ready);
  assign out_valid = (state == C_OUT);
  assign step_go = (state == C_ISSUE) || (in_valid && in_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      step  <= mpp_pkg::ST_LOAD;
      op    <= mpp_pkg::OP_STRAIGHT;
    end else begin
      unique case (state)
        C_IDLE, C_OUT: begin
          if (in_valid && in_ready) begin
            op <= in_op;
            step <= (in_op == mpp_pkg::OP_MEASURE) ? mpp_pkg::ST_E0 : mpp_pkg::ST_DECEL;
            state <= C_ISSUE;
          end else if (state == C_OUT && out_ready) begin
            state <= C_IDLE;
            step <= mpp_pkg::ST_LOAD;
          end
        end
        C_ISSUE: begin
          // park on the load step while the result waits
          if (step == mpp_pkg::ST_FIN || step == mpp_pkg::ST_EFIN) begin
            state <= C_OUT;
            step  <= mpp_pkg::ST_LOAD;
          end else begin
            state <= C_WAIT;
          end
        end
        C_WAIT: if (unit_done) begin
          step  <= nxt;
          state <= C_ISSUE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### rtl/move_profile_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_profile_planner: trapezoidal move planner for a two-wheel base
// Plans straight moves, turns and emergency stops; turns encoder counts
// into wheel position errors.
// ----------------------------------------------------------------------------
//  channel | signals                       | transaction
//  in      | in_valid/in_ready/in_item     | one command item
//  out     | out_valid/out_ready/out_item  | one plan and error snapshot
//  cfg     | cfg_we/cfg_index/cfg_data     | one register write
//
// Steps run in turn on the shared multiply-divide unit (which ends early when the
// quotient saturates) and the square root unit, then the plan is committed.
// A straight move runs the most steps, a brake or measure the fewest.
// Reset clears the plan to zero, directions forward, registers to defaults.
// A held result blocks only until the next command is accepted together
// with the result transaction.
// ----------------------------------------------------------------------------
module move_profile_planner #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mpp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output mpp_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [4:0] step;
  logic       step_go;
  logic       unit_done;

  // sequence the steps; hold the result until taken
  mpp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_op(in_item.operation), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .unit_done(unit_done), .step(step), .step_go(step_go)
  );

  mpp_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .step(step), .step_go(step_go), .item(in_item),
    .unit_done(unit_done), .result(out_item)
  );

endmodule

### rtl/mpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_checker: port-level checks
// Watches the top-level handshakes and result fields.
// ----------------------------------------------------------------------------
module mpp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mpp_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result shown right after accept");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    !out_valid && $past(in_valid && in_ready) |-> !in_ready)
    else $error("accepted while busy");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

bind move_profile_planner mpp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for move_profile_planner
// Drives straight, turn, brake and measure commands under several register
// settings with random idling on both channels, predicts every plan and
// error snapshot in fixed point, and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRAC = 16;
  localparam logic [63:0] PI_C = 64'h3243F6A88;
  localparam logic [63:0] SAT_C = 64'h7FFFFFFF;
  localparam logic [63:0] LIM_C = 64'h3FFFFFFFFFFFFFFF;
  localparam int WATCHDOG = 40000;
  localparam int DRAIN = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mpp_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mpp_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  move_profile_planner #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the registers and plan state
  logic [15:0] dia_r, base_r, decel_r, gear_r, ppr_r;
  logic [31:0] tot_s, brk_s, spd_s;
  logic signed [31:0] cruise_s;
  logic capped_s, rdir_s, ldir_s;
  logic [15:0] adj_s;
  logic signed [31:0] err_s [4];

  mpp_pkg::out_item_t snapshots [$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int op_seen [4];
  int capped_seen = 0;
  bit idle_on = 1'b1;
  bit hold_off = 1'b0;
  int quiet = 0;

  function automatic logic [63:0] nz(logic [15:0] r);
    return (r == 16'd0) ? 64'd1 : {48'd0, r};
  endfunction

  // floor(a*b/d) with saturation at lim
  function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] d, logic [63:0] lim);
    logic [127:0] p;
    logic [127:0] q;
    if (d == 0) return lim;
    p = a * b;
    if (p[127:64] >= d) return lim;
    q = p / d;
    return (q > lim) ? lim : q[63:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] wheel_decel();
    return scaled_quot(nz(decel_r) * 256, PI_C, 30 * nz(gear_r), LIM_C);
  endfunction

  function automatic logic [63:0] brake_angle(logic [63:0] v, logic [63:0] a);
    return scaled_quot(v * v, 64'd1 << (32 - FRAC), 2 * a, SAT_C);
  endfunction

  task automatic plan_trapezoid(logic [63:0] tot, logic [63:0] spd);
    logic [63:0] a, brk, half, s;
    a = wheel_decel();
    brk = brake_angle(spd, a);
    tot_s = tot[31:0];
    if (2 * brk > tot) begin
      half = tot >> 1;
      s = root64(scaled_quot(2 * a, half, 64'd1 << (32 - FRAC), LIM_C));
      brk_s = half[31:0];
      cruise_s = half[31:0];
      spd_s = (s > SAT_C) ? SAT_C[31:0] : s[31:0];
      capped_s = 1'b1;
    end else begin
      brk_s = brk[31:0];
      cruise_s = tot[31:0] - brk[31:0];
      spd_s = spd[31:0];
      capped_s = 1'b0;
    end
  endtask

  function automatic logic signed [31:0] wheel_error(logic signed [63:0] ref_ang,
                                                     logic [31:0] cnt);
    logic [63:0] m, ang;
    logic signed [63:0] e;
    m = cnt[31] ? (64'h100000000 - cnt) : {32'd0, cnt};
    ang = scaled_quot(m * 512, PI_C, (nz(ppr_r) * nz(gear_r)) << (32 - FRAC),
                      64'd1 << 40);
    e = cnt[31] ? ref_ang + $signed(ang) : ref_ang - $signed(ang);
    if (e > 64'sd2147483647) e = 64'sd2147483647;
    if (e < -64'sd2147483648) e = -64'sd2147483648;
    return e[31:0];
  endfunction

  function automatic logic [63:0] abs16(logic [15:0] x);
    return x[15] ? (64'h10000 - x) : {48'd0, x};
  endfunction

  // Advance the predictor by one command and queue the resulting snapshot
  task automatic predict_snapshot(mpp_pkg::in_item_t it);
    logic [63:0] cm, sp, tot, spd, deg;
    logic signed [31:0] e100, e10;
    int band;
    mpp_pkg::out_item_t o;
    e100 = 100 <<< FRAC;
    e10 = 10 <<< FRAC;
    case (mpp_pkg::op_t'(it.operation))
      mpp_pkg::OP_STRAIGHT: begin
        cm = abs16(it.distance_mm) / 10;
        sp = abs16(it.speed_mm_s) / 10;
        tot = scaled_quot(cm * 512, 64'd1 << FRAC, nz(dia_r), SAT_C);
        spd = scaled_quot(sp * 512, 64'd1 << FRAC, nz(dia_r), SAT_C);
        rdir_s = !it.distance_mm[15] && it.distance_mm != 0;
        ldir_s = rdir_s;
        plan_trapezoid(tot, spd);
        adj_s = 16'd66;
        for (int k = 0; k < 4; k++) err_s[k] = e100;
      end
      mpp_pkg::OP_TURN: begin
        deg = abs16(it.turn_degrees);
        tot = scaled_quot(deg * nz(base_r) * 2, PI_C, (360 * nz(dia_r)) << (32 - FRAC),
                          SAT_C);
        band = (deg > 15) + (deg > 30) + (deg > 60) + (deg > 90) + (deg > 120)
             + (deg > 150);
        plan_trapezoid(tot, 64'd5 << (FRAC - 1));
        rdir_s = !(!it.turn_degrees[15] && it.turn_degrees != 0);
        ldir_s = !rdir_s;
        err_s[0] = e100; err_s[1] = e100; err_s[2] = e10; err_s[3] = e10;
        case (band)
          0: adj_s = 16'd328;
          1: adj_s = 16'd655;
          2: adj_s = 16'd983;
          3: adj_s = 16'd5243;
          4: adj_s = 16'd6554;
          5: adj_s = 16'd9830;
          default: adj_s = 16'd16384;
        endcase
      end
      mpp_pkg::OP_BRAKE: begin
        tot = brake_angle({32'd0, spd_s}, wheel_decel());
        brk_s = tot[31:0];
        tot_s = tot[31:0];
        spd_s = 0;
        err_s[2] = e100; err_s[3] = e100;
      end
      default: begin
        err_s[0] = wheel_error(cruise_s, it.right_count);
        err_s[1] = wheel_error(cruise_s, it.left_count);
        err_s[2] = wheel_error({32'd0, tot_s}, it.right_count);
        err_s[3] = wheel_error({32'd0, tot_s}, it.left_count);
      end
    endcase
    if (capped_s) capped_seen++;
    o.total_distance = tot_s[30:0];
    o.brake_distance = brk_s[30:0];
    o.cruise_distance = cruise_s;
    o.final_speed = spd_s[30:0];
    o.speed_capped = capped_s;
    o.right_forward = rdir_s;
    o.left_forward = ldir_s;
    o.stop_adjust = adj_s;
    o.err_right = err_s[0];
    o.err_left = err_s[1];
    o.err_right_total = err_s[2];
    o.err_left_total = err_s[3];
    snapshots.push_back(o);
  endtask

  // Send one command; idle a random burst first when enabled.
  // Valid stays high after acceptance until the next idle or drain drops it.
  task automatic send_command(mpp_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_snapshot(it);
    op_seen[it.operation]++;
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (snapshots.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      mpp_pkg::REG_DIA:   dia_r = val;
      mpp_pkg::REG_BASE:  base_r = val;
      mpp_pkg::REG_DECEL: decel_r = val;
      mpp_pkg::REG_GEAR:  gear_r = val;
      mpp_pkg::REG_PPR:   ppr_r = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] d, logic [15:0] b, logic [15:0] a,
                          logic [15:0] g, logic [15:0] p);
    wait_drained();
    write_reg(mpp_pkg::REG_DIA, d);
    write_reg(mpp_pkg::REG_BASE, b);
    write_reg(mpp_pkg::REG_DECEL, a);
    write_reg(mpp_pkg::REG_GEAR, g);
    write_reg(mpp_pkg::REG_PPR, p);
    cfg_we <= 1'b0;
  endtask

  function automatic mpp_pkg::in_item_t make_cmd(mpp_pkg::op_t op, logic [15:0] move_mm,
                                                 logic [15:0] spd, logic [15:0] deg,
                                                 logic [31:0] rc, logic [31:0] lc);
    mpp_pkg::in_item_t it;
    it.operation = op;
    it.distance_mm = move_mm;
    it.speed_mm_s = spd;
    it.turn_degrees = deg;
    it.right_count = rc;
    it.left_count = lc;
    return it;
  endfunction

  function automatic mpp_pkg::in_item_t random_cmd();
    logic [15:0] move_mm, spd, deg;
    // Mostly realistic moves, sometimes full-range values
    move_mm = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(0, 6000) - 3000);
    spd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    deg = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
    return make_cmd(mpp_pkg::op_t'($urandom_range(0, 3)), move_mm, spd, deg,
                    ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 4000) - 2000),
                    ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 4000) - 2000));
  endfunction

  // Check each result transaction against the oldest snapshot
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (snapshots.size() == 0) begin
        $display("%0t: result with no command pending: %h", $time, out_item);
        errors++;
      end else begin
        mpp_pkg::out_item_t e;
        e = snapshots.pop_front();
        n_checked++;
        if (e.total_distance != out_item.total_distance)
          $display("%0t: total_distance exp %h got %h", $time, e.total_distance,
                   out_item.total_distance);
        if (e.brake_distance != out_item.brake_distance)
          $display("%0t: brake_distance exp %h got %h", $time, e.brake_distance,
                   out_item.brake_distance);
        if (e.cruise_distance != out_item.cruise_distance)
          $display("%0t: cruise_distance exp %h got %h", $time, e.cruise_distance,
                   out_item.cruise_distance);
        if (e.final_speed != out_item.final_speed)
          $display("%0t: final_speed exp %h got %h", $time, e.final_speed,
                   out_item.final_speed);
        if (e.speed_capped != out_item.speed_capped)
          $display("%0t: speed_capped exp %b got %b", $time, e.speed_capped,
                   out_item.speed_capped);
        if (e.right_forward != out_item.right_forward)
          $display("%0t: right_forward exp %b got %b", $time, e.right_forward,
                   out_item.right_forward);
        if (e.left_forward != out_item.left_forward)
          $display("%0t: left_forward exp %b got %b", $time, e.left_forward,
                   out_item.left_forward);
        if (e.stop_adjust != out_item.stop_adjust)
          $display("%0t: stop_adjust exp %h got %h", $time, e.stop_adjust,
                   out_item.stop_adjust);
        if (e.err_right != out_item.err_right)
          $display("%0t: err_right exp %h got %h", $time, e.err_right, out_item.err_right);
        if (e.err_left != out_item.err_left)
          $display("%0t: err_left exp %h got %h", $time, e.err_left, out_item.err_left);
        if (e.err_right_total != out_item.err_right_total)
          $display("%0t: err_right_total exp %h got %h", $time, e.err_right_total,
                   out_item.err_right_total);
        if (e.err_left_total != out_item.err_left_total)
          $display("%0t: err_left_total exp %h got %h", $time, e.err_left_total,
                   out_item.err_left_total);
        if (e !== out_item) errors++;
      end
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, none late in the run
  always @(posedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("move_profile_planner: mismatch");
      $finish;
    end
  end

  task automatic test_directed();
    int degs [8] = '{0, 15, 16, 31, 61, 91, 121, 180};
    send_command(make_cmd(mpp_pkg::OP_MEASURE, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000));
    send_command(make_cmd(mpp_pkg::OP_STRAIGHT, 16'sh7FFF, 16'sh7FFF, 0, 0, 0));
    send_command(make_cmd(mpp_pkg::OP_STRAIGHT, 16'sh8000, 16'sh8000, 0, 0, 0));
    send_command(make_cmd(mpp_pkg::OP_STRAIGHT, 0, 100, 0, 0, 0));
    send_command(make_cmd(mpp_pkg::OP_STRAIGHT, 1000, 300, 16'hFFFF, 0, 0));
    send_command(make_cmd(mpp_pkg::OP_STRAIGHT, 9, 9, 0, 0, 0));
    send_command(make_cmd(mpp_pkg::OP_BRAKE, 0, 0, 0, 0, 0));
    send_command(make_cmd(mpp_pkg::OP_MEASURE, 0, 0, 0, 32'hFFFFFFFF, 32'd1));
    foreach (degs[i]) send_command(make_cmd(mpp_pkg::OP_TURN, 0, 0, 16'(degs[i]), 0, 0));
    send_command(make_cmd(mpp_pkg::OP_TURN, 0, 0, -16'sd90, 0, 0));
    send_command(make_cmd(mpp_pkg::OP_TURN, 0, 0, 16'sh8000, 0, 0));
    send_command(make_cmd(mpp_pkg::OP_TURN, 0, 0, 16'sh7FFF, 0, 0));
    send_command(make_cmd(mpp_pkg::OP_MEASURE, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF));
    send_command(make_cmd(mpp_pkg::OP_BRAKE, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int count);
    repeat (count) send_command(random_cmd());
  endtask

  // Block the receiver so the block backs up, then release it
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(6);
    join
    wait_drained();
    test_random(6);
  endtask

  initial begin
    dia_r = 1536; base_r = 7680; decel_r = 100; gear_r = 7680; ppr_r = 48;
    tot_s = 0; brk_s = 0; spd_s = 0; cruise_s = 0; capped_s = 0;
    rdir_s = 1; ldir_s = 1; adj_s = 0;
    for (int k = 0; k < 4; k++) err_s[k] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(200);
    test_backpressure();
    set_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    test_directed();
    test_random(100);
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random(100);
    set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    test_random(60);
    set_regs(16'($urandom_range(256, 8192)), 16'($urandom), 16'($urandom_range(1, 3000)),
             16'($urandom), 16'($urandom_range(1, 2000)));
    test_random(150);
    set_regs(16'd1536, 16'd7680, 16'd100, 16'd7680, 16'd48);
    test_random(150);
    idle_on = 1'b0;
    test_random(120);

    wait_drained();
    $display("Sent %0d commands (straight %0d, turn %0d, brake %0d, measure %0d),",
             n_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("checked %0d results, %0d capped plans, over six register settings.",
             n_checked, capped_seen);
    if (errors == 0 && snapshots.size() == 0) begin
      $display("move_profile_planner: match");
    end else begin
      $display("move_profile_planner: mismatch");
    end
    $finish;
  end
endmodule
